// ----- hw/rtl/alc_pkg.sv -----
// ----------------------------------------------------------------------------
// List-with-cursor package
// Shared sizes, operation and status codes for the list-with-cursor unit.
// ----------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned IdxW        = $clog2(Capacity);
  localparam int unsigned CntW        = $clog2(Capacity + 1);
  localparam int unsigned DataW       = 32;
  localparam int unsigned EntryCountW = 7;

  typedef enum logic [1:0] {
    OpAppend = 2'd0,
    OpFirst  = 2'd1,
    OpNext   = 2'd2,
    OpRemove = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StatOk    = 3'd0,
    StatFull  = 3'd1,
    StatEmpty = 3'd2,
    StatEnd   = 3'd3,
    StatNoCur = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ----- hw/rtl/array_list_with_cursor_unit.sv -----
// ----------------------------------------------------------------------------
// List-with-cursor unit
// Bounded list of data words in one synchronous RAM, with a single read
// cursor: append, read first, read next and remove current.
// ----------------------------------------------------------------------------
// Usage:
//   An input item (operation_i, value_i) is taken on in_valid_i && in_ready_o.
//   Every item gives exactly one result item (status_o, read_value_o,
//   entry_count_o), delivered on out_valid_o && out_ready_i.
//   Append and refused operations go from acceptance to the Done state and
//   then to the output register; read first and read next pass through the
//   Read state first, and remove passes through Read and then the Shift
//   loop, which moves every later entry down one slot, one RAM read and one
//   RAM write per cycle; the shift loop through the single-read, single-write
//   RAM sets the remove cost.
//   The unit takes a new item as soon as the previous one has left its
//   working stages; a result that waits in the output register does not
//   block acceptance. If the receiver stalls, the next result waits in a
//   holding stage and no further item is taken until it moves on.
//   Reset empties the list and clears the cursor; RAM contents are left
//   undefined and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_with_cursor_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire alc_pkg::op_e                        operation_i,
  input  wire logic signed [alc_pkg::DataW-1:0]    value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output alc_pkg::status_e                         status_o,
  output logic signed [alc_pkg::DataW-1:0]         read_value_o,
  output logic [alc_pkg::EntryCountW-1:0]          entry_count_o
);
  import alc_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRead  = 4'b0010,
    StShift = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  logic                rem_q, rem_d;
  logic [IdxW-1:0]     src_q, src_d;
  status_e             res_status_q, res_status_d;
  logic [DataW-1:0]    res_value_q, res_value_d;
  logic [CntW-1:0]     res_count_q, res_count_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [DataW-1:0]    out_value_q;
  logic [CntW-1:0]     out_count_q;

  logic [DataW-1:0]    mem_q [Capacity];
  logic [DataW-1:0]    rdata_q;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  logic [DataW-1:0]    mem_wdata;

  logic                accept, load_out;
  logic [CntW-1:0]     nxt, cur_ext, step;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign cur_ext    = CntW'(cur_q);
  assign nxt        = cur_valid_q ? (cur_ext + CntW'(1)) : '0;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    src_d        = src_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_count_d  = res_count_q;
    mem_we       = 1'b0;
    mem_waddr    = src_q - IdxW'(1);
    mem_wdata    = rdata_q;
    mem_re       = 1'b0;
    mem_raddr    = src_q;
    step         = CntW'(src_q) + CntW'(1);

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_value_d = '0;
          res_status_d = StatOk;
          res_count_d = count_q;
          rem_d = 1'b0;
          state_d = StDone;
          case (operation_i)
            OpAppend: begin
              if (count_q >= CntW'(Capacity)) begin
                res_status_d = StatFull;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = count_q[IdxW-1:0];
                mem_wdata   = value_i;
                count_d     = count_q + CntW'(1);
                res_count_d = count_q + CntW'(1);
              end
            end
            OpFirst: begin
              if (count_q == '0) begin
                res_status_d = StatEmpty;
              end else begin
                cur_valid_d = 1'b1;
                cur_d       = '0;
                mem_re      = 1'b1;
                mem_raddr   = '0;
                state_d     = StRead;
              end
            end
            OpNext: begin
              if (nxt >= count_q) begin
                res_status_d = StatEnd;
              end else begin
                cur_valid_d = 1'b1;
                cur_d       = nxt[IdxW-1:0];
                mem_re      = 1'b1;
                mem_raddr   = nxt[IdxW-1:0];
                state_d     = StRead;
              end
            end
            default: begin
              if (!cur_valid_q || cur_ext >= count_q) begin
                res_status_d = StatNoCur;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cur_q;
                rem_d     = 1'b1;
                state_d   = StRead;
              end
            end
          endcase
        end
      end
      StRead: begin
        res_value_d = rdata_q;
        state_d = StDone;
        if (rem_q) begin
          step = cur_ext + CntW'(1);
          if (step < count_q) begin
            mem_re    = 1'b1;
            mem_raddr = step[IdxW-1:0];
            src_d     = step[IdxW-1:0];
            state_d   = StShift;
          end else begin
            count_d     = count_q - CntW'(1);
            res_count_d = count_q - CntW'(1);
            cur_valid_d = (cur_q != '0);
            cur_d       = cur_q - IdxW'(1);
          end
        end
      end
      StShift: begin
        mem_we = 1'b1;
        if (step < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = step[IdxW-1:0];
          src_d     = step[IdxW-1:0];
        end else begin
          count_d     = count_q - CntW'(1);
          res_count_d = count_q - CntW'(1);
          cur_valid_d = (cur_q != '0);
          cur_d       = cur_q - IdxW'(1);
          state_d     = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      rem_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
      cur_q       <= cur_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_count_q  <= res_count_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= res_count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_value_q;
  assign entry_count_o = EntryCountW'(out_count_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_ext < count_q))
    else $error("cursor points past the last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (CntW'(src_q) < count_q) && (src_q > cur_q))
    else $error("shift source out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("RAM read and write collide on one entry");

endmodule

`default_nettype wire
